@@ rtl/circular_deque_assert.svh @@
// Assertion macros shared by the circular deque checker.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cdq_pkg.sv @@
// Shared constants, types and helper functions of the circular deque.
package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int OUT_W      = 32;
    localparam int IN_W       = 32;
    localparam int CFG_W      = 5;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_RESET  = 16;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic  we;
        t_idx  addr;
        t_data data;
    } t_mem_wr;

    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] front_value;
        logic [OUT_W-1:0] rear_value;
        logic             is_empty;
        logic             is_full;
        t_cnt             count;
    } t_result;

    // Effective capacity: the register value held within 1..DEPTH.
    function automatic t_cnt clamp_cap(logic [CFG_W-1:0] v);
        t_cnt c;
        if (v == '0) begin
            c = CNT_W'(1);
        end else if (32'(v) > 32'(DEPTH)) begin
            c = CNT_W'(DEPTH);
        end else begin
            c = CNT_W'(v);
        end
        return c;
    endfunction

    function automatic t_idx ptr_inc(t_idx p, t_cnt cap);
        t_idx r;
        if (CNT_W'(p) == cap - CNT_W'(1)) begin
            r = '0;
        end else begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

    function automatic t_idx ptr_dec(t_idx p, t_cnt cap);
        t_idx r;
        if (p == '0) begin
            r = IDX_W'(cap - CNT_W'(1));
        end else begin
            r = p - IDX_W'(1);
        end
        return r;
    endfunction

    function automatic t_data to_data(logic [IN_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(t_data d);
        return OUT_W'(d);
    endfunction

endpackage

@@ rtl/cdq_mem.sv @@
// Entry storage: one write port and two registered read ports with write bypass.
module cdq_mem (
    input  logic             i_clk,
    input  cdq_pkg::t_mem_wr i_wr,
    input  cdq_pkg::t_idx    i_rd_front_addr,
    input  cdq_pkg::t_idx    i_rd_rear_addr,
    output cdq_pkg::t_data   o_rd_front_data,
    output cdq_pkg::t_data   o_rd_rear_data
);

    cdq_pkg::t_data r_mem [cdq_pkg::DEPTH];
    cdq_pkg::t_data r_rd_front;
    cdq_pkg::t_data r_rd_rear;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // A read of the address being written returns the new word.
    always_ff @(posedge i_clk) begin
        if (i_wr.we && (i_wr.addr == i_rd_front_addr)) begin
            r_rd_front <= i_wr.data;
        end else begin
            r_rd_front <= r_mem[i_rd_front_addr];
        end
        if (i_wr.we && (i_wr.addr == i_rd_rear_addr)) begin
            r_rd_rear <= i_wr.data;
        end else begin
            r_rd_rear <= r_mem[i_rd_rear_addr];
        end
    end

    assign o_rd_front_data = r_rd_front;
    assign o_rd_rear_data  = r_rd_rear;

endmodule

@@ rtl/cdq_ctrl.sv @@
// Pointer, count and end-value state of the deque, with the operation decode.
module cdq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cdq_pkg::CFG_W-1:0]     i_cfg_capacity,
    input  logic                          i_exec,
    input  logic [cdq_pkg::MODE_W-1:0]    i_mode,
    input  logic [cdq_pkg::IN_W-1:0]      i_value,
    input  cdq_pkg::t_data                i_rd_front,
    input  cdq_pkg::t_data                i_rd_rear,
    output cdq_pkg::t_mem_wr              o_wr,
    output cdq_pkg::t_idx                 o_rd_front_addr,
    output cdq_pkg::t_idx                 o_rd_rear_addr,
    output cdq_pkg::t_result              o_result
);

    cdq_pkg::t_cnt  r_cap, n_cap;
    cdq_pkg::t_idx  r_front, n_front;
    cdq_pkg::t_idx  r_rear, n_rear;
    cdq_pkg::t_cnt  r_count, n_count;
    cdq_pkg::t_data r_front_val, n_front_val;
    cdq_pkg::t_data r_rear_val, n_rear_val;
    cdq_pkg::t_data data;
    logic           ok;
    logic           has_room;
    logic           has_entry;

    assign data      = cdq_pkg::to_data(i_value);
    assign has_room  = (r_count != r_cap);
    assign has_entry = (r_count != '0);

    always_comb begin
        n_cap       = r_cap;
        n_front     = r_front;
        n_rear      = r_rear;
        n_count     = r_count;
        n_front_val = r_front_val;
        n_rear_val  = r_rear_val;
        ok          = 1'b0;
        o_wr.we     = 1'b0;
        o_wr.addr   = '0;
        o_wr.data   = data;
        if (i_cfg_we) begin
            n_cap   = cdq_pkg::clamp_cap(i_cfg_capacity);
            n_front = '0;
            n_rear  = cdq_pkg::IDX_W'(n_cap - cdq_pkg::CNT_W'(1));
            n_count = '0;
        end else if (i_exec) begin
            unique case (i_mode)
                cdq_pkg::MODE_PUSH_FRONT: begin
                    if (has_room) begin
                        ok          = 1'b1;
                        n_front     = cdq_pkg::ptr_dec(r_front, r_cap);
                        o_wr.we     = 1'b1;
                        o_wr.addr   = n_front;
                        n_front_val = data;
                        if (!has_entry) begin
                            n_rear     = n_front;
                            n_rear_val = data;
                        end
                        n_count = r_count + cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_PUSH_BACK: begin
                    if (has_room) begin
                        ok         = 1'b1;
                        n_rear     = cdq_pkg::ptr_inc(r_rear, r_cap);
                        o_wr.we    = 1'b1;
                        o_wr.addr  = n_rear;
                        n_rear_val = data;
                        if (!has_entry) begin
                            n_front     = n_rear;
                            n_front_val = data;
                        end
                        n_count = r_count + cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_POP_FRONT: begin
                    if (has_entry) begin
                        ok          = 1'b1;
                        n_front     = cdq_pkg::ptr_inc(r_front, r_cap);
                        n_front_val = i_rd_front;
                        n_count     = r_count - cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_POP_BACK: begin
                    if (has_entry) begin
                        ok         = 1'b1;
                        n_rear     = cdq_pkg::ptr_dec(r_rear, r_cap);
                        n_rear_val = i_rd_rear;
                        n_count    = r_count - cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::MODE_PEEK: begin
                    ok = 1'b1;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    // The neighbors of the next front and rear are fetched into the read registers
    // ahead of time, so that a pop finds the new end word already registered.
    assign o_rd_front_addr = cdq_pkg::ptr_inc(n_front, n_cap);
    assign o_rd_rear_addr  = cdq_pkg::ptr_dec(n_rear, n_cap);

    always_comb begin
        o_result.ok       = ok;
        o_result.is_empty = (n_count == '0);
        o_result.is_full  = (n_count == n_cap);
        o_result.count    = n_count;
        if (n_count == '0) begin
            o_result.front_value = '1;
            o_result.rear_value  = '1;
        end else begin
            o_result.front_value = cdq_pkg::to_out(n_front_val);
            o_result.rear_value  = cdq_pkg::to_out(n_rear_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= cdq_pkg::clamp_cap(cdq_pkg::CFG_W'(cdq_pkg::CAP_RESET));
            r_front <= '0;
            r_rear  <= cdq_pkg::IDX_W'(cdq_pkg::clamp_cap(cdq_pkg::CFG_W'(cdq_pkg::CAP_RESET))
                       - cdq_pkg::CNT_W'(1));
            r_count <= '0;
        end else begin
            r_cap   <= n_cap;
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val <= n_front_val;
        r_rear_val  <= n_rear_val;
    end

endmodule

@@ rtl/circular_deque.sv @@
// Top level of the circular deque: input register, operation core and result register.
//
// Usage: each item on the input channel (i_in_valid / o_in_stall) carries a
// mode (push front, push back, pop front, pop back, peek) and a data word.
// Every item gives exactly one result on the output channel (o_out_valid /
// i_out_stall): success flag, front and rear words (-1 when empty), empty
// and full flags and the entry count, all as they stand after the operation.
// An item is taken into the input register and executed from there once the
// result register is free or not stalled; its result is then offered from the
// result register. One item is accepted every cycle while the output does not
// stall, which the pointer update and the one write port of the entry storage
// allow; its two read ports prefetch the words next to the front and rear.
// The capacity register is written on i_cfg_valid / o_cfg_ready; a write
// empties the deque. Ready is low while an item waits in the input register.
// After reset the deque is empty with a capacity of 16; the storage needs
// no clearing. While the receiver stalls, the result holds and one more item
// can still enter the input register before o_in_stall rises.
module circular_deque (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic        [cdq_pkg::MODE_W-1:0]    i_mode,
    input  logic signed [cdq_pkg::IN_W-1:0]      i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_ok,
    output logic signed [cdq_pkg::OUT_W-1:0]     o_front_value,
    output logic signed [cdq_pkg::OUT_W-1:0]     o_rear_value,
    output logic                                 o_is_empty,
    output logic                                 o_is_full,
    output logic        [cdq_pkg::CNT_W-1:0]     o_count,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [cdq_pkg::CFG_W-1:0]     i_cfg_capacity
);

    logic                          r_in_valid;
    logic [cdq_pkg::MODE_W-1:0]    r_mode;
    logic [cdq_pkg::IN_W-1:0]      r_value;
    logic                          r_out_valid;
    cdq_pkg::t_result              r_result;
    cdq_pkg::t_result              result;
    cdq_pkg::t_mem_wr              wr;
    cdq_pkg::t_idx                 rd_front_addr;
    cdq_pkg::t_idx                 rd_rear_addr;
    cdq_pkg::t_data                rd_front;
    cdq_pkg::t_data                rd_rear;
    logic                          exec;
    logic                          cfg_we;

    assign exec        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign o_cfg_ready = !r_in_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode  <= i_mode;
            r_value <= $unsigned(i_value);
        end
    end

    cdq_ctrl u_cdq_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_exec          (exec),
        .i_mode          (r_mode),
        .i_value         (r_value),
        .i_rd_front      (rd_front),
        .i_rd_rear       (rd_rear),
        .o_wr            (wr),
        .o_rd_front_addr (rd_front_addr),
        .o_rd_rear_addr  (rd_rear_addr),
        .o_result        (result)
    );

    cdq_mem u_cdq_mem (
        .i_clk           (i_clk),
        .i_wr            (wr),
        .i_rd_front_addr (rd_front_addr),
        .i_rd_rear_addr  (rd_rear_addr),
        .o_rd_front_data (rd_front),
        .o_rd_rear_data  (rd_rear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_result.ok;
    assign o_front_value = $signed(r_result.front_value);
    assign o_rear_value  = $signed(r_result.rear_value);
    assign o_is_empty    = r_result.is_empty;
    assign o_is_full     = r_result.is_full;
    assign o_count       = r_result.count;

endmodule

@@ rtl/cdq_checker.sv @@
// Port-level checker for the circular deque and its bind to the top level.
`include "circular_deque_assert.svh"

module cdq_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [cdq_pkg::OUT_W-1:0]     o_front_value,
    input logic signed [cdq_pkg::OUT_W-1:0]     o_rear_value,
    input logic                                 o_is_empty,
    input logic                                 o_is_full,
    input logic        [cdq_pkg::CNT_W-1:0]     o_count
);

    // The empty flag and the count must agree.
    `CDQ_ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n, o_out_valid, o_is_empty == (o_count == '0), "empty flag disagrees with count")

    // An empty deque reports -1 at both ends.
    `CDQ_ASSERT_IMPLY(a_empty_values, i_clk, i_rst_n, o_out_valid && o_is_empty, (o_front_value == -32'sd1) && (o_rear_value == -32'sd1), "empty deque shows end words")

    // Capacity is at least one, so full and empty never coincide, and the count stays in range.
    `CDQ_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, o_out_valid, !(o_is_full && o_is_empty) && (32'(o_count) <= 32'(cdq_pkg::DEPTH)), "count out of range")

    // A stalled result stays offered unchanged.
    `CDQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_count) && $stable(o_front_value) && $stable(o_rear_value), "stalled result changed")

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_front_value (o_front_value),
    .o_rear_value  (o_rear_value),
    .o_is_empty    (o_is_empty),
    .o_is_full     (o_is_full),
    .o_count       (o_count)
);
